>>> design/relay_feedback_monitor_defines.svh
// ---------------------------------------------------------------------------
// relay feedback monitor assertion macros
// shared assertion shorthands for the relay feedback monitor rtl
// ---------------------------------------------------------------------------
`ifndef RELAY_FEEDBACK_MONITOR_DEFINES_SVH
`define RELAY_FEEDBACK_MONITOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RFM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("relay feedback monitor check failed");

// next-cycle implication, disabled in reset
`define RFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("relay feedback monitor check failed");

`endif

>>> design/rfm_pkg.sv
// ---------------------------------------------------------------------------
// relay feedback monitor package
// widths, codes, reset values and beat types shared by the monitor rtl
// ---------------------------------------------------------------------------
`default_nettype none

package rfm_pkg;

  localparam int unsigned ChanW    = 4;
  localparam int unsigned MvW      = 12;
  localparam int unsigned SumW     = 14;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ConfW    = 16;
  localparam int unsigned StableW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // command codes; the unused code acts as a status report
  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  typedef enum logic [1:0] {
    MODE_SYNC    = 2'd0,
    MODE_OVR_ON  = 2'd1,
    MODE_OVR_OFF = 2'd2,
    MODE_UNKNOWN = 2'd3
  } mode_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FEEDBACK_PRESENT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ANALOG_SENSE     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ON_MAX_MV        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_OFF_MIN_MV       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STABLE_SAMPLES   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CONFIRM_MS       = 3'd5;

  // configuration reset values
  localparam logic               RST_FEEDBACK_PRESENT = 1'b1;
  localparam logic               RST_ANALOG_SENSE     = 1'b1;
  localparam logic [MvW-1:0]     RST_ON_MAX_MV        = 12'd1000;
  localparam logic [MvW-1:0]     RST_OFF_MIN_MV       = 12'd2500;
  localparam logic [StableW-1:0] RST_STABLE_SAMPLES   = 3'd3;
  localparam logic [ConfW-1:0]   RST_CONFIRM_MS       = 16'd400;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ChanW-1:0] channel;
    logic             level;
    logic [MvW-1:0]   sample_a;
    logic [MvW-1:0]   sample_b;
    logic [MvW-1:0]   sample_c;
    logic [MvW-1:0]   sample_d;
    logic [TimeW-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [ChanW-1:0] out_channel;
    logic             commanded_state;
    logic             actual_state;
    logic [1:0]       relay_mode;
    logic [MvW-1:0]   sense_mv;
    logic             notify;
    logic             persist;
    logic             override_alert;
  } rsp_t;

endpackage

`default_nettype wire

>>> design/rfm_in_if.sv
// ---------------------------------------------------------------------------
// relay feedback monitor request channel
// valid/ready channel carrying one request beat
// ---------------------------------------------------------------------------
`default_nettype none

interface rfm_in_if;
  logic          valid;
  logic          ready;
  rfm_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/rfm_out_if.sv
// ---------------------------------------------------------------------------
// relay feedback monitor result channel
// valid/ready channel carrying one result beat
// ---------------------------------------------------------------------------
`default_nettype none

interface rfm_out_if;
  logic          valid;
  logic          ready;
  rfm_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/relay_feedback_monitor.sv
// ---------------------------------------------------------------------------
// relay feedback monitor
// per-channel relay command / feedback tracker with debounce and override
// detection; one result beat for every request beat
// ---------------------------------------------------------------------------
//
//   channel   dir  kind          beat contents
//   req_i     in   valid/ready   cmd, channel, level, four mv samples, now_ms
//   rsp_o     out  valid/ready   channel, commanded/actual state, mode, mv, flags
//   cfg_*     in   write only    register index and data, no read-back
//
// one request beat per cycle unless the result side stalls; its result sits
// in the output register in the cycle after acceptance. the per-channel state
// is read, updated and written back in the accepting cycle, so back-to-back
// beats on the same channel see each other. a stalled result blocks the
// request side only while the output register is full and rsp_o.ready is low.
// reset clears all channel state and loads the configuration defaults, no clearing pass.
//
`default_nettype none
`include "relay_feedback_monitor_defines.svh"

module relay_feedback_monitor #(
  parameter int unsigned CHANNELS = 4
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  rfm_in_if.sink                           req_i,
  rfm_out_if.source                        rsp_o,
  input  wire                              cfg_we_i,
  input  wire  [rfm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [rfm_pkg::CfgDataW-1:0]     cfg_data_i
);
  import rfm_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ChanW:0] ChanLimit = (ChanW + 1)'(CHANNELS);

  // configuration registers
  logic               fb_present_q;
  logic               analog_q;
  logic [MvW-1:0]     on_max_q;
  logic [MvW-1:0]     off_min_q;
  logic [StableW-1:0] stable_q;
  logic [ConfW-1:0]   confirm_q;

  // per-channel state
  logic               cmd_q     [CHANNELS];
  logic               act_q     [CHANNELS];
  mode_e              mode_q    [CHANNELS];
  logic [MvW-1:0]     sense_q   [CHANNELS];
  logic               cand_q    [CHANNELS];
  logic [StableW-1:0] cnt_q     [CHANNELS];
  logic [TimeW-1:0]   start_q   [CHANNELS];

  // output register
  logic rsp_valid_q;
  rsp_t rsp_q;
  rsp_t rsp_d;

  // next values for the addressed channel
  logic               n_cmd;
  logic               n_act;
  mode_e              n_mode;
  logic [MvW-1:0]     n_sense;
  logic               n_cand;
  logic [StableW-1:0] n_cnt;
  logic [TimeW-1:0]   n_start;

  logic               req_fire;
  logic               in_range;
  logic [IdxW-1:0]    idx;
  logic               wr_en;

  // sample classification
  logic [SumW-1:0]    mv_sum;
  logic [MvW-1:0]     mv_avg;
  logic [MvW-1:0]     meas_mv;
  logic               meas;
  logic               meas_ok;

  req_t               req;

  // terms for the checks
  logic               chk_alert;
  logic               chk_alert_ok;
  logic               chk_persist;
  logic               chk_stray;
  logic               chk_stray_ok;

  assign req         = req_i.payload;
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign in_range    = {1'b0, req.channel} < ChanLimit;
  assign idx         = in_range ? req.channel[IdxW-1:0] : '0;
  assign wr_en       = req_fire && in_range;

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // analog sense: average of the four readings, then the two-threshold test
  // (energized test first, so overlapping thresholds read as energized); else the inverted level
  assign mv_sum = SumW'(req.sample_a) + SumW'(req.sample_b)
                + SumW'(req.sample_c) + SumW'(req.sample_d);
  assign mv_avg = mv_sum[SumW-1:2];

  always_comb begin
    if (!analog_q) begin
      meas    = ~req.level;
      meas_ok = 1'b1;
      meas_mv = '0;
    end else if (mv_avg <= on_max_q) begin
      meas    = 1'b1;
      meas_ok = 1'b1;
      meas_mv = mv_avg;
    end else if (mv_avg >= off_min_q) begin
      meas    = 1'b0;
      meas_ok = 1'b1;
      meas_mv = mv_avg;
    end else begin
      meas    = 1'b0;
      meas_ok = 1'b0;
      meas_mv = mv_avg;
    end
  end

  // state update for the addressed channel
  always_comb begin
    logic               cur_cmd;
    logic               cur_act;
    mode_e              cur_mode;
    logic               cur_cand;
    logic [StableW-1:0] cur_cnt;
    logic [TimeW-1:0]   cur_start;
    logic [StableW-1:0] cnt_inc;
    logic [TimeW-1:0]   elapsed;
    logic               take_lvl;
    mode_e              new_mode;
    logic               notify;
    logic               persist;
    logic               alert;

    cur_cmd   = cmd_q[idx];
    cur_act   = act_q[idx];
    cur_mode  = mode_q[idx];
    cur_cand  = cand_q[idx];
    cur_cnt   = cnt_q[idx];
    cur_start = start_q[idx];
    cnt_inc   = cur_cnt + 3'd1;
    elapsed   = req.now_ms - cur_start;
    take_lvl  = 1'b1;
    new_mode  = cur_mode;
    notify    = 1'b0;
    persist   = 1'b0;
    alert     = 1'b0;

    n_cmd   = cur_cmd;
    n_act   = cur_act;
    n_mode  = cur_mode;
    n_sense = sense_q[idx];
    n_cand  = cur_cand;
    n_cnt   = cur_cnt;
    n_start = cur_start;

    case (req.cmd)
      CMD_SET: begin
        if (cur_cmd != req.level) begin
          n_cmd   = req.level;
          n_start = req.now_ms;
          persist = 1'b1;
          // without sense hardware the command stands in for feedback
          if (!fb_present_q) begin
            n_act  = req.level;
            n_mode = MODE_SYNC;
            notify = 1'b1;
          end
        end
      end
      CMD_SAMPLE: begin
        if (fb_present_q) begin
          n_sense = meas_mv;
          if (!meas_ok) begin
            // reading between thresholds
            n_cnt = '0;
            if (cur_mode != MODE_UNKNOWN) begin
              n_mode = MODE_UNKNOWN;
              notify = 1'b1;
            end
          end else if (cur_cand != meas) begin
            // new candidate level, restart debounce
            n_cand = meas;
            n_cnt  = 3'd1;
          end else begin
            if (cur_cnt < stable_q) begin
              n_cnt = cnt_inc;
              if (cnt_inc < stable_q) begin
                take_lvl = 1'b0;
              end
            end
            if (take_lvl) begin
              if (meas == cur_cmd) begin
                new_mode = MODE_SYNC;
                n_start  = req.now_ms;
              end else if (elapsed >= TimeW'(confirm_q)) begin
                // mismatch held long enough, declare override
                new_mode = meas ? MODE_OVR_ON : MODE_OVR_OFF;
              end
              if (meas != cur_act || new_mode != cur_mode) begin
                n_act  = meas;
                n_mode = new_mode;
                notify = 1'b1;
                alert  = (cur_mode != MODE_OVR_ON && cur_mode != MODE_OVR_OFF)
                      && (new_mode == MODE_OVR_ON || new_mode == MODE_OVR_OFF);
              end
            end
          end
        end
      end
      default: begin
        // status report: nothing changes
      end
    endcase

    rsp_d.out_channel = req.channel;
    if (in_range) begin
      rsp_d.commanded_state = n_cmd;
      rsp_d.actual_state    = n_act;
      rsp_d.relay_mode      = n_mode;
      rsp_d.sense_mv        = n_sense;
      rsp_d.notify          = notify;
      rsp_d.persist         = persist;
      rsp_d.override_alert  = alert;
    end else begin
      // channel beyond the table: fixed unknown result
      rsp_d.commanded_state = 1'b0;
      rsp_d.actual_state    = 1'b0;
      rsp_d.relay_mode      = MODE_UNKNOWN;
      rsp_d.sense_mv        = '0;
      rsp_d.notify          = 1'b0;
      rsp_d.persist         = 1'b0;
      rsp_d.override_alert  = 1'b0;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_present_q <= RST_FEEDBACK_PRESENT;
      analog_q     <= RST_ANALOG_SENSE;
      on_max_q     <= RST_ON_MAX_MV;
      off_min_q    <= RST_OFF_MIN_MV;
      stable_q     <= RST_STABLE_SAMPLES;
      confirm_q    <= RST_CONFIRM_MS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FEEDBACK_PRESENT: fb_present_q <= cfg_data_i[0];
        CFG_ANALOG_SENSE:     analog_q     <= cfg_data_i[0];
        CFG_ON_MAX_MV:        on_max_q     <= cfg_data_i[MvW-1:0];
        CFG_OFF_MIN_MV:       off_min_q    <= cfg_data_i[MvW-1:0];
        CFG_STABLE_SAMPLES:   stable_q     <= cfg_data_i[StableW-1:0];
        CFG_CONFIRM_MS:       confirm_q    <= cfg_data_i[ConfW-1:0];
        default: begin
        end
      endcase
    end
  end

  // channel state write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cmd_q[i]   <= 1'b0;
        act_q[i]   <= 1'b0;
        mode_q[i]  <= MODE_UNKNOWN;
        sense_q[i] <= '0;
        cand_q[i]  <= 1'b0;
        cnt_q[i]   <= '0;
        start_q[i] <= '0;
      end
    end else if (wr_en) begin
      cmd_q[idx]   <= n_cmd;
      act_q[idx]   <= n_act;
      mode_q[idx]  <= n_mode;
      sense_q[idx] <= n_sense;
      cand_q[idx]  <= n_cand;
      cnt_q[idx]   <= n_cnt;
      start_q[idx] <= n_start;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_q <= rsp_d;
    end
  end

  // checks
  assign chk_alert    = rsp_valid_q && rsp_q.override_alert;
  assign chk_alert_ok = rsp_q.notify
                     && (rsp_q.relay_mode == MODE_OVR_ON || rsp_q.relay_mode == MODE_OVR_OFF);
  assign chk_persist  = rsp_valid_q && rsp_q.persist;
  assign chk_stray    = rsp_valid_q && ({1'b0, rsp_q.out_channel} >= ChanLimit);
  assign chk_stray_ok = rsp_q.relay_mode == MODE_UNKNOWN && !rsp_q.notify && !rsp_q.persist;

  `RFM_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, req_fire, rsp_valid_q)
  `RFM_ASSERT_IMP(a_alert_is_override, clk_i, rst_ni, chk_alert, chk_alert_ok)
  `RFM_ASSERT_IMP(a_persist_no_alert, clk_i, rst_ni, chk_persist, !rsp_q.override_alert)
  `RFM_ASSERT_IMP(a_out_of_range_quiet, clk_i, rst_ni, chk_stray, chk_stray_ok)

endmodule

`default_nettype wire
